FILE: hdl/jtmc_pkg.sv
// Shared types, constants and the arctangent table for the joystick to motion command block.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package jtmc_pkg;

  localparam int NUM_AXES     = 6;
  localparam int NUM_BUTTONS  = 16;
  localparam int SAMPLE_WIDTH = 16;

  localparam int AXIS_IDX_W = 3;
  localparam int BTN_IDX_W  = 4;
  localparam int BTN_CNT_W  = 5;
  localparam int SCALE_W    = 16;
  localparam int SPEED_W    = 17;
  localparam int ANG_W      = 16;
  localparam int CORDIC_W   = 28;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Stream widths: input tdata holds six axes, the button mask and the button count.
  localparam int IN_BITS    = NUM_AXES * SAMPLE_WIDTH + NUM_BUTTONS + BTN_CNT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * SPEED_W + ANG_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 8;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CTRL = 2'd1;
  localparam logic [1:0] MODE_KEEP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MAP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MODE  = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              mul_rot;
    logic              mul_trans;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } jtmc_cmd_t;

  typedef struct packed {
    logic out_full;
  } jtmc_status_t;

  // Arctangent of 2^-i as a binary angle (32768 = pi).
  function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      4'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/jtmc_cordic.sv
// Iterative vectoring CORDIC that turns the heading vector into a binary angle.
// Depends on jtmc_pkg for widths and the arctangent table.
module jtmc_cordic (
  input  logic                                    clk_i,
  input  logic                                    init_i,
  input  logic signed [jtmc_pkg::SAMPLE_WIDTH-1:0] x_i,
  input  logic signed [jtmc_pkg::SAMPLE_WIDTH-1:0] y_i,
  input  logic                                    step_en_i,
  input  logic        [jtmc_pkg::STEP_W-1:0]       step_i,
  output logic        [jtmc_pkg::ANG_W-1:0]        heading_o
);

  localparam int W = jtmc_pkg::CORDIC_W;

  logic signed [W-1:0] u_q, u_d, v_q, v_d;
  logic [jtmc_pkg::ANG_W-1:0] acc_q, acc_d;
  logic zero_q, zero_d;

  logic signed [W-1:0] xe, ye, u0, v0, u_sh, v_sh;
  logic [jtmc_pkg::ANG_W-1:0] acc0;

  always_comb begin
    xe = W'(x_i);
    ye = W'(y_i);
    u0 = ye;
    v0 = xe;
    acc0 = '0;
    // A vector in the lower half plane is first turned by a quarter turn.
    if (y_i < 0) begin
      if (x_i >= 0) begin
        u0 = xe;
        v0 = -ye;
        acc0 = 16'h4000;
      end else begin
        u0 = -xe;
        v0 = ye;
        acc0 = 16'hC000;
      end
    end
    u_sh = u_q >>> step_i;
    v_sh = v_q >>> step_i;
    u_d = u_q;
    v_d = v_q;
    acc_d = acc_q;
    zero_d = zero_q;
    if (init_i) begin
      u_d = u0 <<< 8;
      v_d = v0 <<< 8;
      acc_d = acc0;
      zero_d = (x_i == '0) && (y_i == '0);
    end else if (step_en_i) begin
      if (v_q >= 0) begin
        u_d = u_q + v_sh;
        v_d = v_q - u_sh;
        acc_d = acc_q + jtmc_pkg::atan_step(step_i);
      end else begin
        u_d = u_q - v_sh;
        v_d = v_q + u_sh;
        acc_d = acc_q - jtmc_pkg::atan_step(step_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    acc_q <= acc_d;
    zero_q <= zero_d;
  end

  assign heading_o = zero_q ? '0 : acc_q;

endmodule

FILE: hdl/jtmc_dp.sv
// Datapath: configuration registers, mode selection, axis shaping, the shared
// scaling multiplier, the CORDIC and the output register. Uses jtmc_pkg and jtmc_cordic.
module jtmc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  jtmc_pkg::jtmc_cmd_t                   cmd_i,
  output jtmc_pkg::jtmc_status_t                status_o,
  input  logic                                  cfg_we_i,
  input  logic [jtmc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [jtmc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [jtmc_pkg::IN_DATA_W-1:0]        in_data_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [jtmc_pkg::OUT_DATA_W-1:0]       out_data_o,
  output logic [jtmc_pkg::OUT_USER_W-1:0]       out_user_o
);

  localparam int SW = jtmc_pkg::SAMPLE_WIDTH;
  localparam int NA = jtmc_pkg::NUM_AXES;
  localparam int NB = jtmc_pkg::NUM_BUTTONS;
  localparam int PW = SW + jtmc_pkg::SCALE_W + 2;

  logic [11:0] axis_sel_q;
  logic [63:0] deadzones_q;
  logic [3:0]  invert_q;
  logic [jtmc_pkg::SCALE_W-1:0] max_speed_q, max_rot_q;
  logic [14:0] button_map_q;
  logic [1:0]  mode_q, mode_d;

  logic signed [SW-1:0] hx_q, hy_q, rot_q, trans_q;
  logic signed [jtmc_pkg::SPEED_W-1:0] rot_p_q, trans_p_q;

  logic out_valid_q;
  logic [jtmc_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [jtmc_pkg::OUT_USER_W-1:0] out_user_q;

  logic signed [SW-1:0] axes [NA];
  logic [NB-1:0] mask;
  logic [jtmc_pkg::BTN_CNT_W-1:0] count;
  logic [jtmc_pkg::ANG_W-1:0] heading;

  logic signed [SW:0] mul_a;
  logic signed [jtmc_pkg::SCALE_W:0] mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      axes[k] = in_data_i[k*SW +: SW];
    end
  end
  assign mask  = in_data_i[NA*SW +: NB];
  assign count = in_data_i[NA*SW+NB +: jtmc_pkg::BTN_CNT_W];

  function automatic logic button_hit(input logic [4:0] entry,
                                      input logic [NB-1:0] m,
                                      input logic [jtmc_pkg::BTN_CNT_W-1:0] c);
    logic [jtmc_pkg::BTN_IDX_W-1:0] idx;
    logic present;
    idx = entry[3:0];
    present = ({1'b0, idx} < c) && ({1'b0, idx} < jtmc_pkg::BTN_CNT_W'(NB));
    return entry[4] && present && m[idx];
  endfunction

  // Apply the deadzone and then the optional inversion to one selected axis.
  function automatic logic signed [SW-1:0] shape(input logic [15:0] dz,
                                                 input logic inv,
                                                 input logic signed [SW-1:0] a_in);
    logic signed [SW-1:0] a;
    logic signed [SW:0] ax, mag, neg;
    a = a_in;
    ax = (SW+1)'(a);
    mag = (a < 0) ? -ax : ax;
    if (mag < $signed({1'b0, dz})) begin
      a = '0;
    end
    if (inv) begin
      neg = -((SW+1)'(a));
      if (neg == $signed((SW+1)'(1) <<< (SW-1))) begin
        a = {1'b0, {(SW-1){1'b1}}};
      end else begin
        a = neg[SW-1:0];
      end
    end
    return a;
  endfunction

  function automatic logic signed [SW-1:0] pick(input logic [2:0] idx,
                                                input logic signed [SW-1:0] ax [NA]);
    logic signed [SW-1:0] r;
    r = '0;
    for (int k = 0; k < NA; k++) begin
      if (32'(idx) == k) begin
        r = ax[k];
      end
    end
    return r;
  endfunction

  // Off wins over control, and control over keep-alive.
  always_comb begin
    mode_d = mode_q;
    if (cmd_i.load) begin
      if (button_hit(button_map_q[4:0], mask, count)) begin
        mode_d = jtmc_pkg::MODE_OFF;
      end else if (button_hit(button_map_q[9:5], mask, count)) begin
        mode_d = jtmc_pkg::MODE_CTRL;
      end else if (button_hit(button_map_q[14:10], mask, count)) begin
        mode_d = jtmc_pkg::MODE_KEEP;
      end
    end else if (cfg_we_i && cfg_idx_i == jtmc_pkg::CFG_START_MODE &&
                 cfg_data_i[1:0] != 2'd3) begin
      mode_d = cfg_data_i[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_sel_q   <= '0;
      deadzones_q  <= '0;
      invert_q     <= '0;
      max_speed_q  <= '0;
      max_rot_q    <= '0;
      button_map_q <= '0;
      mode_q       <= jtmc_pkg::MODE_OFF;
    end else begin
      mode_q <= mode_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jtmc_pkg::CFG_AXIS_SELECT: axis_sel_q   <= cfg_data_i[11:0];
          jtmc_pkg::CFG_DEADZONES:   deadzones_q  <= cfg_data_i;
          jtmc_pkg::CFG_INVERT_MASK: invert_q     <= cfg_data_i[3:0];
          jtmc_pkg::CFG_MAX_SPEED:   max_speed_q  <= cfg_data_i[15:0];
          jtmc_pkg::CFG_MAX_ROT:     max_rot_q    <= cfg_data_i[15:0];
          jtmc_pkg::CFG_BUTTON_MAP:  button_map_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  logic signed [SW-1:0] sel [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (32'(axis_sel_q[3*k +: 3]) < NA) begin
        sel[k] = shape(deadzones_q[16*k +: 16], invert_q[k],
                       pick(axis_sel_q[3*k +: 3], axes));
      end else begin
        sel[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hx_q    <= sel[0];
      hy_q    <= sel[1];
      rot_q   <= sel[2];
      trans_q <= sel[3];
    end
  end

  // One multiplier serves rotation, then translation; the floor shift is a bit select.
  assign mul_a = cmd_i.mul_rot ? (SW+1)'(rot_q) : (SW+1)'(trans_q);
  assign mul_b = cmd_i.mul_rot ? $signed({1'b0, max_rot_q}) : $signed({1'b0, max_speed_q});
  assign prod  = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_rot) begin
      rot_p_q <= prod[SW-1 +: jtmc_pkg::SPEED_W];
    end
    if (cmd_i.mul_trans) begin
      trans_p_q <= prod[SW-1 +: jtmc_pkg::SPEED_W];
    end
  end

  jtmc_cordic u_cordic (
    .clk_i     (clk_i),
    .init_i    (cmd_i.mul_rot),
    .x_i       (hx_q),
    .y_i       (hy_q),
    .step_en_i (cmd_i.iter),
    .step_i    (cmd_i.step),
    .heading_o (heading)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_user_q <= {5'd0, mode_q == jtmc_pkg::MODE_KEEP, mode_q};
      if (mode_q == jtmc_pkg::MODE_CTRL) begin
        out_data_q <= jtmc_pkg::OUT_DATA_W'({heading, rot_p_q, trans_p_q});
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

FILE: hdl/jtmc_ctrl.sv
// Controller state machine that sequences one request through the datapath.
// Depends on jtmc_pkg for the command and status types.
module jtmc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  jtmc_pkg::jtmc_status_t status_i,
  output jtmc_pkg::jtmc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULR = 3'd1;
  localparam logic [2:0] ST_MULT = 3'd2;
  localparam logic [2:0] ST_ITER = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [jtmc_pkg::STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_MULR;
        end
      end
      ST_MULR: begin
        cmd_o.mul_rot = 1'b1;
        state_d = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_trans = 1'b1;
        step_d = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.iter = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here until the output register can take the result.
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: hdl/joystick_to_motion_command.sv
// Joystick sample to motion command converter, top level.
// In order: the idle state accepts a request, the shared scaling multiplier takes the rotation
// and then the translation, the CORDIC unit runs its 16 steps and the output register loads.
// A new request is accepted only once the controller is back in idle.
// A stalled master side holds the controller in its final state until the result moves.
// Reset: asynchronous, active low; clears the mode to off and the configuration to zero.
module joystick_to_motion_command (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // axis_0..axis_5 (16 bits each), buttons_pressed (16), button_count (5), zero fill
  input  logic [jtmc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // translation (17), rotation (17), heading (16), zero fill
  output logic [jtmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // mode (2), hold (1), zero fill
  output logic [jtmc_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [jtmc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [jtmc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  jtmc_pkg::jtmc_cmd_t    cmd;
  jtmc_pkg::jtmc_status_t status;

  jtmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jtmc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

FILE: hdl/jtmc_checker.sv
// Port-level checker for joystick_to_motion_command, attached by the bind below.
// Depends on jtmc_pkg for widths and mode codes.
module jtmc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [jtmc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [jtmc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // Keep-alive results carry the hold flag and no motion.
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == jtmc_pkg::MODE_KEEP |->
      m_axis_tuser[2] && m_axis_tdata == '0)
    else $error("keep-alive result carries motion");

  // Off results carry no motion and no hold flag.
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == jtmc_pkg::MODE_OFF |->
      !m_axis_tuser[2] && m_axis_tdata == '0)
    else $error("off result carries motion");

  // Control results never raise hold, and no result carries the unused mode code.
  a_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3 &&
      (m_axis_tuser[1:0] != jtmc_pkg::MODE_CTRL || !m_axis_tuser[2]))
    else $error("bad mode or hold in result");

endmodule

bind joystick_to_motion_command jtmc_checker u_jtmc_checker (.*);
